@@ hw/rtl/putcc_pkg.sv @@
// ----------------------------------------------------------------------------
// putcc_pkg
// shared types, constants and helpers for the per-user traffic class counter
// ----------------------------------------------------------------------------
package putcc_pkg;

    localparam int MAX_USERS_DEF = 32;
    localparam int NUM_AC        = 4;
    localparam int NUM_CLASS     = 4;
    localparam int NUM_RESULTS   = NUM_AC * NUM_CLASS;
    localparam int CTR_W         = 32;
    localparam int MASK_W        = 32;

    localparam logic [7:0]       PROTO_TCP = 8'd6;
    localparam logic [7:0]       PROTO_UDP = 8'd17;
    localparam logic [CTR_W-1:0] CTR_MAX   = '1;

    // configuration register indexes
    localparam int         CFG_IDX_W            = 2;
    localparam logic [1:0] CFG_ACTIVE_USER_MASK = 2'd0;
    localparam logic [1:0] CFG_BUSY_THRESHOLD   = 2'd1;
    localparam logic [1:0] CFG_MIN_IP_LENGTH    = 2'd2;

    typedef struct packed {
        logic        func;
        logic [4:0]  user_index;
        logic        direction;
        logic [2:0]  traffic_id;
        logic [15:0] ip_total_length;
        logic [7:0]  ip_protocol;
        logic [3:0]  ip_header_words;
        logic [3:0]  tcp_offset_words;
    } t_in_word;

    typedef struct packed {
        logic [1:0] access_category;
        logic [1:0] traffic_class;
        logic [5:0] busy_user_count;
        logic       last_result;
    } t_out_word;

    // standard tid to access category map
    function automatic logic [1:0] tid_to_ac(input logic [2:0] tid);
        logic [1:0] ac;
        case (tid)
            3'd0, 3'd3: ac = 2'd0;
            3'd1, 3'd2: ac = 2'd1;
            3'd4, 3'd5: ac = 2'd2;
            default:    ac = 2'd3;
        endcase
        return ac;
    endfunction

endpackage

@@ hw/rtl/putcc_ram.sv @@
// ----------------------------------------------------------------------------
// putcc_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module putcc_ram #(
    parameter int P_WIDTH = 32,
    parameter int P_DEPTH = 512
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/per_user_traffic_class_counter_top.sv @@
// ----------------------------------------------------------------------------
// per_user_traffic_class_counter_top
// per-user, per-access-category, per-class saturating packet counters with a
// sweep that reports busy user counts and clears the active users' counters
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | word
//  --------+-----------+-------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_word  (t_in_word)
//  out     | output    | o_out_valid/i_out_stall | o_out_word (t_out_word)
//  cfg     | input     | i_cfg_we                | i_cfg_index, i_cfg_data
//
//  packet word: when counted, a read in idle, then a saturating write back;
//    a dropped word leaves the block idle; one ram read-modify-write sets the pace
//  sweep word: 16 results, each with one user per cycle through the threshold
//    comparator, then a drain state and a hand-off state that waits while
//    the output is stalled
//  after reset a clearing pass writes zero to all MAX_USERS*16 counters,
//    one per cycle; o_in_stall is high meanwhile, config writes still land
//  the output register lets a result wait while the sweep moves on
//
module per_user_traffic_class_counter_top #(
    parameter int MAX_USERS = putcc_pkg::MAX_USERS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input words
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  putcc_pkg::t_in_word          i_in_word,
    // result words
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output putcc_pkg::t_out_word         o_out_word,
    // configuration writes
    input  logic                         i_cfg_we,
    input  logic [putcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [putcc_pkg::CTR_W-1:0]  i_cfg_data
);

    import putcc_pkg::*;

    // user index width, at least one bit
    localparam int UW          = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
    localparam int AW          = UW + 4;
    localparam int DEPTH       = MAX_USERS * NUM_RESULTS;
    // users past the mask width are never active, so the sweep stops there
    localparam int SWEEP_USERS = (MAX_USERS < MASK_W) ? MAX_USERS : MASK_W;
    localparam logic [UW-1:0] LAST_USER = UW'(SWEEP_USERS - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [3:0]    LAST_K    = 4'(NUM_RESULTS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PKT_WR,
        ST_SWEEP,
        ST_TAIL,
        ST_EMIT
    } t_state;

    t_state             r_state;

    // configuration
    logic [MASK_W-1:0]  r_mask;
    logic [CTR_W-1:0]   r_thr;
    logic [15:0]        r_min_len;

    // sequencer state
    logic [AW-1:0]      r_clr_addr;
    logic [AW-1:0]      r_pkt_addr;
    logic [UW-1:0]      r_user;
    logic [UW-1:0]      r_cmp_user;
    logic               r_cmp_vld;
    logic [3:0]         r_k;
    logic [5:0]         r_busy;

    // output register
    logic               r_out_valid;
    t_out_word          r_out_word;

    // ram port
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [CTR_W-1:0]   ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [CTR_W-1:0]   ram_rdata;

    // packet qualification, straight from the input word
    logic               in_take;
    logic               pkt_active;
    logic               pkt_long;
    logic               is_tcp;
    logic               is_udp;
    logic [16:0]        hdr_sum;
    logic               pure_ack;
    logic               pkt_count;
    logic [AW-1:0]      pkt_addr;

    // shared threshold comparator
    logic               sweep_active;
    logic               hit;
    logic               out_free;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        pkt_active = ({2'b00, i_in_word.user_index} < 7'(MAX_USERS))
                     && r_mask[i_in_word.user_index];
        pkt_long   = i_in_word.ip_total_length >= r_min_len;
        is_tcp     = i_in_word.ip_protocol == PROTO_TCP;
        is_udp     = i_in_word.ip_protocol == PROTO_UDP;
        // a payload that would go negative never matches, so an unsigned
        // compare against the header sum is the same test
        hdr_sum    = {11'd0, i_in_word.ip_header_words, 2'b00}
                   + {11'd0, i_in_word.tcp_offset_words, 2'b00};
        pure_ack   = is_tcp && ({1'b0, i_in_word.ip_total_length} == hdr_sum);
        pkt_count  = pkt_active && pkt_long && (is_udp || (is_tcp && !pure_ack));
        pkt_addr   = {UW'(i_in_word.user_index), tid_to_ac(i_in_word.traffic_id),
                      i_in_word.direction, is_tcp};
    end

    // one user per cycle: compare the counter read last cycle
    assign sweep_active = r_mask[5'(r_cmp_user)];
    assign hit          = r_cmp_vld && sweep_active && (ram_rdata > r_thr);

    // ram port mux
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pkt_addr;
        ram_wdata = '0;
        ram_raddr = {r_user, r_k};
        case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
            end
            ST_IDLE: begin
                ram_raddr = pkt_addr;
            end
            ST_PKT_WR: begin
                ram_we    = 1'b1;
                ram_wdata = (ram_rdata == CTR_MAX) ? ram_rdata
                                                   : ram_rdata + CTR_W'(1);
            end
            ST_SWEEP, ST_TAIL: begin
                // clear active users' counters right behind the read
                ram_we    = r_cmp_vld && sweep_active;
                ram_waddr = {r_cmp_user, r_k};
            end
            default: begin
            end
        endcase
    end

    putcc_ram #(
        .P_WIDTH (CTR_W),
        .P_DEPTH (DEPTH)
    ) u_ctr_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_thr     <= '0;
            r_min_len <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACTIVE_USER_MASK: r_mask    <= i_cfg_data;
                CFG_BUSY_THRESHOLD:   r_thr     <= i_cfg_data;
                CFG_MIN_IP_LENGTH:    r_min_len <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_user      <= '0;
            r_cmp_user  <= '0;
            r_cmp_vld   <= 1'b0;
            r_k         <= '0;
            r_busy      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the emit state loads the output register itself
            if (r_out_valid && !i_out_stall && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            if (hit) begin
                r_busy <= r_busy + 6'd1;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_take) begin
                        if (i_in_word.func) begin
                            r_user    <= '0;
                            r_k       <= '0;
                            r_busy    <= '0;
                            r_cmp_vld <= 1'b0;
                            r_state   <= ST_SWEEP;
                        end else if (pkt_count) begin
                            r_pkt_addr <= pkt_addr;
                            r_state    <= ST_PKT_WR;
                        end
                    end
                end
                ST_PKT_WR: begin
                    r_state <= ST_IDLE;
                end
                ST_SWEEP: begin
                    r_cmp_vld  <= 1'b1;
                    r_cmp_user <= r_user;
                    if (r_user == LAST_USER) begin
                        r_state <= ST_TAIL;
                    end else begin
                        r_user <= r_user + UW'(1);
                    end
                end
                ST_TAIL: begin
                    r_cmp_vld <= 1'b0;
                    r_state   <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_out_valid                <= 1'b1;
                        r_out_word.access_category <= r_k[3:2];
                        r_out_word.traffic_class   <= r_k[1:0];
                        r_out_word.busy_user_count <= r_busy;
                        r_out_word.last_result     <= (r_k == LAST_K);
                        r_busy                     <= '0;
                        r_user                     <= '0;
                        if (r_k == LAST_K) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_k     <= r_k + 4'd1;
                            r_state <= ST_SWEEP;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // busy count never passes the number of users swept
    a_busy_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy <= 6'(SWEEP_USERS))
        else $error("busy count beyond user count");

    // sweep clears only active users' counters
    a_sweep_clear_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (r_state == ST_SWEEP || r_state == ST_TAIL))
            |-> (r_mask[5'(r_cmp_user)] && ram_wdata == '0))
        else $error("sweep wrote an inactive user");

    // a packet write back never wraps to zero
    a_pkt_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PKT_WR) |-> (ram_we && ram_wdata != '0))
        else $error("counter wrapped");

    // the final result of a sweep returns the block to idle
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && out_free && r_k == LAST_K) |=> (r_state == ST_IDLE))
        else $error("sweep did not end after last result");

endmodule

@@ verif/traffic_count_checker.sv @@
// ----------------------------------------------------------------------------
// traffic_count_checker
// watches the packet, result and register ports of the per-user traffic class
// counter, keeps its own copy of the counters and compares every result word
// ----------------------------------------------------------------------------
package traffic_count_tb_pkg;

    localparam logic FUNC_PACKET = 1'b0;
    localparam logic FUNC_SWEEP  = 1'b1;
    localparam logic DIR_RX      = 1'b0;
    localparam logic DIR_TX      = 1'b1;

endpackage

module traffic_count_checker #(
    parameter int MAX_USERS = putcc_pkg::MAX_USERS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  putcc_pkg::t_in_word                 i_in_word,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  putcc_pkg::t_out_word                i_out_word,
    input  logic                                i_cfg_we,
    input  logic [putcc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [putcc_pkg::CTR_W-1:0]         i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import putcc_pkg::*;
    import traffic_count_tb_pkg::*;

    localparam int NUM_COUNTERS = MAX_USERS * NUM_RESULTS;

    // tid to access category, standard wmm mapping
    localparam logic [1:0] AC_OF_TID [8] = '{2'd0, 2'd1, 2'd1, 2'd0, 2'd2, 2'd2, 2'd3, 2'd3};

    logic [MASK_W-1:0] user_mask;
    logic [CTR_W-1:0]  busy_threshold;
    logic [15:0]       min_length;
    logic [CTR_W-1:0]  packet_count [NUM_COUNTERS];
    t_out_word         busy_count_q [$];
    int                fail_count;

    assign o_fail_count = fail_count;

    function automatic bit user_is_active(input int user);
        if (user >= MASK_W || user >= MAX_USERS)
            return 1'b0;
        return user_mask[user];
    endfunction

    function automatic int counter_slot(input int user, input int ac, input int cls);
        return (user * NUM_AC + ac) * NUM_CLASS + cls;
    endfunction

    function automatic void count_packet_word(input t_in_word w);
        int user;
        int cls;
        int payload;
        int slot;
        user = int'(w.user_index);
        if (!user_is_active(user) || w.ip_total_length < min_length)
            return;
        if (w.ip_protocol == PROTO_UDP) begin
            cls = {w.direction, 1'b0};
        end else if (w.ip_protocol == PROTO_TCP) begin
            // signed, so a short packet never looks like a pure ack
            payload = int'(w.ip_total_length) - 4 * int'(w.ip_header_words);
            if (payload == 4 * int'(w.tcp_offset_words))
                return;
            cls = {w.direction, 1'b1};
        end else begin
            return;
        end
        slot = counter_slot(user, int'(AC_OF_TID[w.traffic_id]), cls);
        if (packet_count[slot] != CTR_MAX)
            packet_count[slot] = packet_count[slot] + 1'b1;
    endfunction

    function automatic void sweep_counters();
        int busy;
        t_out_word r;
        for (int ac = 0; ac < NUM_AC; ac++) begin
            for (int cls = 0; cls < NUM_CLASS; cls++) begin
                busy = 0;
                for (int u = 0; u < MAX_USERS; u++) begin
                    if (user_is_active(u) && packet_count[counter_slot(u, ac, cls)] > busy_threshold)
                        busy++;
                end
                r.access_category = 2'(ac);
                r.traffic_class   = 2'(cls);
                r.busy_user_count = 6'(busy);
                r.last_result     = (ac * NUM_CLASS + cls == NUM_RESULTS - 1);
                busy_count_q.push_back(r);
            end
        end
        // inactive users keep their counts
        for (int u = 0; u < MAX_USERS; u++) begin
            if (user_is_active(u)) begin
                for (int k = 0; k < NUM_RESULTS; k++)
                    packet_count[u * NUM_RESULTS + k] = '0;
            end
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_word want;
        if (!i_rst_n) begin
            user_mask      = '0;
            busy_threshold = '0;
            min_length     = '0;
            for (int i = 0; i < NUM_COUNTERS; i++)
                packet_count[i] = '0;
            busy_count_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (busy_count_q.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = busy_count_q.pop_front();
                    if (i_out_word.access_category != want.access_category)
                        report_mismatch($sformatf("access_category %0d, expected %0d",
                            i_out_word.access_category, want.access_category));
                    if (i_out_word.traffic_class != want.traffic_class)
                        report_mismatch($sformatf("traffic_class %0d, expected %0d",
                            i_out_word.traffic_class, want.traffic_class));
                    if (i_out_word.busy_user_count != want.busy_user_count)
                        report_mismatch($sformatf("busy_user_count %0d, expected %0d (ac %0d cls %0d)",
                            i_out_word.busy_user_count, want.busy_user_count,
                            want.access_category, want.traffic_class));
                    if (i_out_word.last_result != want.last_result)
                        report_mismatch($sformatf("last_result %0b, expected %0b",
                            i_out_word.last_result, want.last_result));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ACTIVE_USER_MASK: user_mask      = i_cfg_data[MASK_W-1:0];
                    CFG_BUSY_THRESHOLD:   busy_threshold = i_cfg_data[CTR_W-1:0];
                    CFG_MIN_IP_LENGTH:    min_length     = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_word.func == FUNC_SWEEP)
                    sweep_counters();
                else
                    count_packet_word(i_in_word);
            end
        end
        o_pending = busy_count_q.size();
    end

endmodule

@@ verif/per_user_traffic_class_counter_top_tb.sv @@
// ----------------------------------------------------------------------------
// per_user_traffic_class_counter_top_tb
// drives packet and sweep words into the traffic class counter under random
// back-pressure on both sides, walks the registers through several settings
// and leaves all checking to the traffic count checker
// ----------------------------------------------------------------------------
module per_user_traffic_class_counter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import putcc_pkg::*;
    import traffic_count_tb_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 6;
    localparam int IDLE_PERCENT    = 35;
    localparam int SWEEP_ODDS      = 12;   // about one sweep in this many words
    localparam int HOLD_OFF_CYCLES = 400;
    // a counted packet still writes back after it is taken; give it some slack
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 40;
    // longest honest silence is the clearing pass after reset or the receiver
    // hold-off; a stalled sweep result adds its pass over the users to the stall
    localparam int WATCHDOG_LIMIT  = 5000;

    localparam logic [7:0]           PROTO_ICMP     = 8'd1;
    localparam logic [7:0]           PROTO_RESERVED = 8'd255;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in_word   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out_word;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CTR_W-1:0]     i_cfg_data  = '0;

    int          fail_count;
    int          pending;
    int          quiet_cycles  = 0;
    logic        calm          = 1'b0;   // no idling on either side
    logic        hold_off_go   = 1'b0;   // set once by the sender
    bit          hold_off_done = 1'b0;
    logic [15:0] cur_min_len   = '0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    per_user_traffic_class_counter_top #(
        .MAX_USERS (MAX_USERS_DEF)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    traffic_count_checker #(
        .MAX_USERS (MAX_USERS_DEF)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_word   (o_out_word),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog: any accepted word or register write counts as progress
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: random stall, one long hold-off when the sender asks
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_go && !hold_off_done) begin
                hold_off_done = 1'b1;
                i_out_stall <= 1'b1;
                // held for the whole stretch so a result waits inside and the sweep backs up
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    function automatic t_in_word make_word(input logic func, input int user,
                                           input logic dir, input int tid,
                                           input int len, input logic [7:0] proto,
                                           input int ihl, input int doff);
        t_in_word w;
        w.func             = func;
        w.user_index       = 5'(user);
        w.direction        = dir;
        w.traffic_id       = 3'(tid);
        w.ip_total_length  = 16'(len);
        w.ip_protocol      = proto;
        w.ip_header_words  = 4'(ihl);
        w.tcp_offset_words = 4'(doff);
        return w;
    endfunction

    // mostly well-formed tcp/udp to a handful of users, some pure acks,
    // some short packets and some words with every field random
    function automatic t_in_word random_packet();
        t_in_word w;
        int       pick;
        int       len;
        w.func             = FUNC_PACKET;
        w.user_index       = ($urandom_range(0, 99) < 60) ? 5'($urandom_range(0, 7))
                                                          : 5'($urandom_range(0, 31));
        w.direction        = 1'($urandom_range(0, 1));
        w.traffic_id       = 3'($urandom_range(0, 7));
        w.ip_header_words  = 4'($urandom_range(0, 15));
        w.tcp_offset_words = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            w.ip_total_length = 16'($urandom());
            w.ip_protocol     = 8'($urandom());
            return w;
        end
        w.ip_protocol = (pick < 57) ? PROTO_TCP : PROTO_UDP;
        if (cur_min_len != 0 && $urandom_range(0, 99) < 10)
            len = $urandom_range(0, int'(cur_min_len) - 1);
        else
            len = int'(cur_min_len) + $urandom_range(0, 1500);
        if (len > 65535)
            len = 65535;
        w.ip_total_length = 16'(len);
        // pure ack: ip length exactly covers both headers
        if (w.ip_protocol == PROTO_TCP && $urandom_range(0, 99) < 20) begin
            w.ip_header_words  = 4'($urandom_range(5, 15));
            w.tcp_offset_words = 4'($urandom_range(5, 15));
            w.ip_total_length  = 16'(4 * (int'(w.ip_header_words) + int'(w.tcp_offset_words)));
        end
        return w;
    endfunction

    // offer one word, hold it until taken, then maybe idle a while
    task automatic send_word(input t_in_word w);
        i_in_word  <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_sweep();
        send_word(make_word(FUNC_SWEEP, 0, DIR_RX, 0, 0, PROTO_UDP, 0, 0));
    endtask

    // sender pauses until every expected result is back and the block settles
    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CTR_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] mask, input logic [31:0] threshold,
                              input logic [31:0] min_len_data);
        write_reg(CFG_ACTIVE_USER_MASK, mask);
        write_reg(CFG_BUSY_THRESHOLD, threshold);
        write_reg(CFG_MIN_IP_LENGTH, min_len_data);
        i_cfg_we    <= 1'b0;
        cur_min_len  = min_len_data[15:0];
    endtask

    task automatic random_run(input int n_words);
        for (int i = 0; i < n_words; i++) begin
            if ($urandom_range(1, SWEEP_ODDS) == 1)
                send_sweep();
            else
                send_word(random_packet());
        end
        send_sweep();
        drain();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every user active, any count is busy, no length floor; the spare
        // register index must be ignored
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
        set_config(32'hFFFF_FFFF, 32'd0, 32'd0);

        // one of each kind: both directions, both protocols, every tid,
        // length and header nibbles at their extremes
        send_word(make_word(FUNC_PACKET, 0, DIR_RX, 0, 0, PROTO_UDP, 0, 0));
        send_word(make_word(FUNC_PACKET, 31, DIR_TX, 7, 65535, PROTO_UDP, 15, 15));
        send_word(make_word(FUNC_PACKET, 1, DIR_RX, 1, 60, PROTO_TCP, 5, 5));
        // pure ack, dropped
        send_word(make_word(FUNC_PACKET, 2, DIR_TX, 2, 40, PROTO_TCP, 5, 5));
        // length shorter than the ip header still counts as data
        send_word(make_word(FUNC_PACKET, 3, DIR_RX, 3, 8, PROTO_TCP, 5, 0));
        // zero-length ack with empty headers, dropped
        send_word(make_word(FUNC_PACKET, 4, DIR_TX, 4, 0, PROTO_TCP, 0, 0));
        send_word(make_word(FUNC_PACKET, 5, DIR_RX, 5, 100, PROTO_ICMP, 5, 5));
        send_word(make_word(FUNC_PACKET, 6, DIR_TX, 6, 100, PROTO_RESERVED, 5, 5));
        // biggest headers, exactly an ack
        send_word(make_word(FUNC_PACKET, 4, DIR_TX, 6, 120, PROTO_TCP, 15, 15));
        send_word(make_word(FUNC_PACKET, 5, DIR_RX, 4, 200, PROTO_UDP, 3, 9));
        send_sweep();
        // counters were just cleared, so this one reports all zero
        send_sweep();
        drain();

        // few users active, threshold of one, length floor of 64
        set_config(32'h8000_000A, 32'd1, 32'd64);
        send_word(make_word(FUNC_PACKET, 1, DIR_RX, 0, 64, PROTO_UDP, 5, 5));
        send_word(make_word(FUNC_PACKET, 1, DIR_RX, 3, 64, PROTO_UDP, 5, 5));
        // one below the floor
        send_word(make_word(FUNC_PACKET, 3, DIR_RX, 0, 63, PROTO_UDP, 5, 5));
        // user outside the mask
        send_word(make_word(FUNC_PACKET, 0, DIR_RX, 0, 64, PROTO_UDP, 5, 5));
        send_word(make_word(FUNC_PACKET, 31, DIR_TX, 7, 100, PROTO_TCP, 5, 5));
        send_word(make_word(FUNC_PACKET, 31, DIR_TX, 6, 100, PROTO_TCP, 5, 5));
        drain();

        // sweep with nobody active neither counts nor clears
        set_config(32'h0000_0000, 32'd1, 32'd64);
        send_sweep();
        drain();
        set_config(32'hFFFF_FFFF, 32'd0, 32'd0);
        send_sweep();
        drain();

        // random phases
        set_config($urandom(), 32'd0, 32'd0);
        random_run(50);

        // long stretch with no idling; junk in the upper data bits of the
        // length register
        calm <= 1'b1;
        set_config(32'hFFFF_FFFF, 32'd2, {16'($urandom()), 16'd40});
        random_run(50);
        calm <= 1'b0;

        // highest threshold and length floor: nothing can ever be busy
        set_config($urandom(), 32'hFFFF_FFFF, 32'h0000_FFFF);
        random_run(40);

        // receiver holds off while words keep coming, so the block backs up
        set_config(32'hFFFF_FFFF, 32'd0, 32'd0);
        hold_off_go <= 1'b1;
        send_sweep();
        random_run(50);

        set_config($urandom() & $urandom(), 32'd1, 32'($urandom_range(0, 1500)));
        random_run(50);

        set_config(32'h0000_0000, 32'd0, 32'd0);
        random_run(30);

        set_config(32'hFFFF_FFFF, 32'd3, 32'd20);
        random_run(40);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ per_user_traffic_class_counter_top.f @@
hw/rtl/putcc_pkg.sv
hw/rtl/putcc_ram.sv
hw/rtl/per_user_traffic_class_counter_top.sv
verif/traffic_count_checker.sv
verif/per_user_traffic_class_counter_top_tb.sv
